@@ rtl/fat12_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fat12_pkg
// Shared types and constants for the FAT12 cluster table engine.
// ---------------------------------------------------------------------------
package fat12_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ENT_W         = 12;
    localparam int SEC_W         = 20;
    localparam int CUR_W         = ENT_W + 1;

    localparam logic [ENT_W-1:0] END_MARK = 12'hFF0;

    localparam logic [1:0] CFG_DATA_START = 2'd0;
    localparam logic [1:0] CFG_SPC        = 2'd1;
    localparam logic [1:0] CFG_COUNT      = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FIND  = 2'd2,
        OP_FREE  = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [ENT_W-1:0] cluster;
        logic [ENT_W-1:0] value;
        logic             in_range;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_DONE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_WALK_TEST,
        ST_WALK_CHK
    } bstate_t;

endpackage

@@ rtl/fat12_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fat12_front
// Input stage: registers a beat, decodes the operation and range-checks it.
// ---------------------------------------------------------------------------
module fat12_front import fat12_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       kind,
    input  logic [ENT_W-1:0] cluster,
    input  logic [ENT_W-1:0] value,
    input  logic             clearing,
    input  logic             q_full,
    output logic             push,
    output cmd_t             push_cmd
);

    logic front_valid_reg, front_valid_next;
    cmd_t cmd_reg;
    logic accept;

    assign in_stall = clearing || (front_valid_reg && q_full);
    assign accept   = in_valid && !in_stall;
    assign push     = front_valid_reg && !q_full;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        front_valid_next = accept || (front_valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.op       <= op_t'(kind);
            cmd_reg.cluster  <= cluster;
            cmd_reg.value    <= value;
            cmd_reg.in_range <= ({1'b0, cluster} < CUR_W'(TABLE_ENTRIES));
        end
    end

endmodule

@@ rtl/fat12_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fat12_queue
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
module fat12_queue import fat12_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/fat12_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fat12_back
// Executes table commands against the entry RAM; owns config and result.
// ---------------------------------------------------------------------------
module fat12_back import fat12_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             q_valid,
    input  cmd_t             head,
    output logic             pop,
    output logic             clearing,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ENT_W-1:0] result_value,
    output logic [SEC_W-1:0] sector,
    output logic             end_of_chain,
    output logic             found
);

    logic [ENT_W-1:0] fat_mem [TABLE_ENTRIES];
    logic [ENT_W-1:0] rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_addr;
    logic [ENT_W-1:0] mem_wdata;

    bstate_t state_reg, state_next;

    logic [15:0]      dss_reg;
    logic [7:0]       spc_reg;
    logic [ENT_W-1:0] ccount_reg;

    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [CUR_W-1:0] cur_reg, cur_next;
    logic [CUR_W-1:0] last_reg, last_next;
    logic [ENT_W-1:0] count_reg, count_next;
    logic             rng_reg, rng_next;
    logic [SEC_W-1:0] prod_reg, prod_next;

    logic             out_valid_reg, out_valid_next;
    logic [ENT_W-1:0] res_reg, res_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic             eoc_reg, eoc_next;
    logic             fnd_reg, fnd_next;

    logic             out_free, done, walk_ok;
    logic [CUR_W-1:0] last_raw;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == ST_IDLE) && q_valid && out_free;
    assign clearing = (state_reg == ST_CLEAR);
    assign walk_ok  = (cur_reg >= CUR_W'(2)) && (cur_reg < {1'b0, END_MARK})
                   && (cur_reg < CUR_W'(TABLE_ENTRIES));
    assign last_raw = {1'b0, ccount_reg} + CUR_W'(1);

    assign out_valid    = out_valid_reg;
    assign result_value = res_reg;
    assign sector       = sec_reg;
    assign end_of_chain = eoc_reg;
    assign found        = fnd_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(TABLE_ENTRIES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (head.op)
                        OP_READ:  state_next = ST_RD_DONE;
                        OP_FIND:  state_next = ST_FIND_RD;
                        OP_FREE:  state_next = ST_WALK_TEST;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD_DONE:   state_next = ST_IDLE;
            ST_FIND_RD:   state_next = (cur_reg > last_reg) ? ST_IDLE : ST_FIND_CHK;
            ST_FIND_CHK:  state_next = (rdata_reg == '0) ? ST_IDLE : ST_FIND_RD;
            ST_WALK_TEST: state_next = walk_ok ? ST_WALK_CHK : ST_IDLE;
            ST_WALK_CHK:  state_next = (rdata_reg == '0) ? ST_IDLE : ST_WALK_TEST;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        mem_we     = 1'b0;
        mem_addr   = cur_reg[IDX_W-1:0];
        mem_wdata  = '0;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        last_next  = last_reg;
        count_next = count_reg;
        rng_next   = rng_reg;
        prod_next  = prod_reg;
        done       = 1'b0;
        res_next   = res_reg;
        sec_next   = sec_reg;
        eoc_next   = eoc_reg;
        fnd_next   = fnd_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + IDX_W'(1);
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    mem_addr   = head.cluster[IDX_W-1:0];
                    rng_next   = head.in_range;
                    prod_next  = SEC_W'((SEC_W'(head.cluster) - SEC_W'(2))
                                        * SEC_W'(spc_reg));
                    cur_next   = (head.op == OP_FIND) ? CUR_W'(2) : {1'b0, head.cluster};
                    last_next  = (last_raw > CUR_W'(TABLE_ENTRIES - 1))
                               ? CUR_W'(TABLE_ENTRIES - 1) : last_raw;
                    count_next = '0;
                    if (head.op == OP_WRITE)
                    begin
                        mem_we    = head.in_range;
                        mem_wdata = head.value;
                        done      = 1'b1;
                        res_next  = '0;
                        sec_next  = '0;
                        eoc_next  = 1'b0;
                        fnd_next  = 1'b0;
                    end
                end
            end
            ST_RD_DONE:
            begin
                done     = 1'b1;
                res_next = rng_reg ? rdata_reg : '0;
                eoc_next = rng_reg && (rdata_reg >= END_MARK);
                sec_next = SEC_W'(dss_reg) + prod_reg;
                fnd_next = 1'b0;
            end
            ST_FIND_RD:
            begin
                if (cur_reg > last_reg)
                begin
                    done     = 1'b1;
                    res_next = '0;
                    sec_next = '0;
                    eoc_next = 1'b0;
                    fnd_next = 1'b0;
                end
            end
            ST_FIND_CHK:
            begin
                if (rdata_reg == '0)
                begin
                    done     = 1'b1;
                    res_next = cur_reg[ENT_W-1:0];
                    sec_next = '0;
                    eoc_next = 1'b0;
                    fnd_next = 1'b1;
                end
                else
                begin
                    cur_next = cur_reg + CUR_W'(1);
                end
            end
            ST_WALK_TEST:
            begin
                if (!walk_ok)
                begin
                    done     = 1'b1;
                    res_next = count_reg;
                    sec_next = '0;
                    eoc_next = 1'b0;
                    fnd_next = 1'b0;
                end
            end
            ST_WALK_CHK:
            begin
                if (rdata_reg == '0)
                begin
                    done     = 1'b1;
                    res_next = count_reg;
                    sec_next = '0;
                    eoc_next = 1'b0;
                    fnd_next = 1'b0;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + ENT_W'(1);
                    cur_next   = {1'b0, rdata_reg};
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
        out_valid_next = done || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fat_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= fat_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            dss_reg       <= 16'd33;
            spc_reg       <= 8'd1;
            ccount_reg    <= 12'd2847;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DATA_START: dss_reg    <= cfg_data;
                    CFG_SPC:        spc_reg    <= cfg_data[7:0];
                    CFG_COUNT:      ccount_reg <= cfg_data[ENT_W-1:0];
                    default:        dss_reg    <= dss_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        last_reg  <= last_next;
        count_reg <= count_next;
        rng_reg   <= rng_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        sec_reg   <= sec_next;
        eoc_reg   <= eoc_next;
        fnd_reg   <= fnd_next;
    end

endmodule

@@ rtl/fat12_cluster_table_engine.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fat12_cluster_table_engine
// FAT12 allocation table with write, read, find-free and free-chain ops.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall) carries one command beat: kind,
//    cluster, value. Output channel (out_valid/out_stall) returns exactly
//    one result beat per command, in order.
//  - Config port (cfg_we/cfg_index/cfg_data) writes data_start_sector,
//    sectors_per_cluster and cluster_count; write only while idle.
//  - After reset the table RAM is cleared one entry per cycle, with
//    in_stall held high. Config writes are taken during that pass.
//  - Find-free reads entries upward from 2 to cluster_count + 1 (capped
//    at 4095); free-chain zeroes each entry along the chain until a
//    free entry or a link outside 2 to 0xFEF. The single RAM port, one
//    access per step, sets the walk and scan rate.
//  - Front stage plus a two-entry queue keep taking beats while the back
//    end works or the result waits; a stalled result holds the back end,
//    and once the queue and the front register fill, in_stall rises.
// ---------------------------------------------------------------------------
module fat12_cluster_table_engine import fat12_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       kind,
    input  logic [ENT_W-1:0] cluster,
    input  logic [ENT_W-1:0] value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ENT_W-1:0] result_value,
    output logic [SEC_W-1:0] sector,
    output logic             end_of_chain,
    output logic             found
);

    logic clearing;
    logic q_full, push, pop, q_valid;
    cmd_t push_cmd, head;

    // command capture and decode
    fat12_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .cluster  (cluster),
        .value    (value),
        .clearing (clearing),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decouples front from the back end
    fat12_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    // table RAM, sequencer and result register
    fat12_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .head         (head),
        .pop          (pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .sector       (sector),
        .end_of_chain (end_of_chain),
        .found        (found)
    );

endmodule
